### src/utf7d_pkg.sv
// Package for the UTF-7 stream decoder: item type, result codes and
// the base64 character classifier. No dependencies.
`default_nettype none

package utf7d_pkg;

    // Result kinds carried in tuser[1:0]
    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes carried in tuser[3:2]
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_PAD      = 2'd2;
    localparam logic [1:0] ERR_NONASCII = 2'd3;

    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_MAX  = 8'h7f;

    localparam int UNIT_BITS  = 16;
    localparam int DIGIT_BITS = 6;
    localparam int STORE_BITS = UNIT_BITS - 1;

    // One classified input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
        logic       b64_ok;
        logic [5:0] b64_val;
        logic       is_plus;
        logic       is_minus;
        logic       high;
    } utf7d_item_t;

    // Returns {valid, value} for a byte of the base64 alphabet
    function automatic logic [6:0] b64_decode(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v  = c - 8'h41;
            ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v  = c - 8'd71;
            ok = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v  = c + 8'd4;
            ok = 1'b1;
        end else if (c == CHAR_PLUS) begin
            v  = 8'd62;
            ok = 1'b1;
        end else if (c == 8'h2f) begin
            v  = 8'd63;
            ok = 1'b1;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

`default_nettype wire

### src/utf7_stream_decoder.sv
// Top level of the UTF-7 stream decoder: front stage, item queue, back stage.
// Depends on utf7d_pkg, utf7d_front, utf7d_queue and utf7d_back.
`default_nettype none

// UTF-7 (RFC 2152) stream decoder. Takes one byte per item on the slave
// stream and gives at most one result per byte on the master stream: a
// UTF-16 code unit, an end-of-stream marker, or an error. Assert s_axis_tlast
// to end a stream (the data byte is then ignored); it always yields one
// result and clears all decoder state so a new stream may follow. After an
// error the decoder drops bytes silently until end of stream. The block
// sustains one byte per clock cycle while the master stream does not stall:
// the front stage registers and classifies each byte, a two-entry queue
// decouples it from the back stage, and the back stage updates the mode and
// 15-bit bit buffer for each item. A result passes the front register, a
// queue slot and the output register before it is presented on the master
// stream. Both sides may stall independently; while a result waits
// in the output register the back stage holds, and the front register and
// the queue still absorb up to three more input bytes.

module utf7_stream_decoder
    import utf7d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
    output logic [3:0]       m_axis_tuser    // [1:0] kind, [3:2] error_code
);

    logic        fr_valid;
    logic        fr_ready;
    utf7d_item_t fr_item;
    logic        q_valid;
    logic        q_ready;
    utf7d_item_t q_item;
    logic [1:0]  res_kind;
    logic [1:0]  res_err;

    utf7d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_eos    (s_axis_tlast),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    // Lets the front keep accepting while the back waits on the output
    utf7d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    utf7d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (m_axis_tdata),
        .out_kind  (res_kind),
        .out_err   (res_err)
    );

    assign m_axis_tuser = {res_err, res_kind};

endmodule

`default_nettype wire

### src/utf7d_front.sv
// Front stage of the UTF-7 decoder: accepts input items and classifies them.
// Depends on utf7d_pkg.
`default_nettype none

module utf7d_front
    import utf7d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_eos,
    output logic             out_valid,
    input  wire logic        out_ready,
    output utf7d_item_t      out_item
);

    logic        valid_reg;
    logic        valid_next;
    utf7d_item_t item_reg;
    utf7d_item_t item_next;
    logic [6:0]  dec;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        dec                 = b64_decode(in_byte);
        item_next.data_byte = in_byte;
        item_next.eos       = in_eos;
        item_next.b64_ok    = dec[6];
        item_next.b64_val   = dec[5:0];
        item_next.is_plus   = (in_byte == CHAR_PLUS);
        item_next.is_minus  = (in_byte == CHAR_MINUS);
        item_next.high      = (in_byte > ASCII_MAX);
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### src/utf7d_queue.sv
// Two-entry queue of classified items between front and back stages.
// Depends on utf7d_pkg.
`default_nettype none

module utf7d_queue
    import utf7d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire utf7d_item_t push_item,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output utf7d_item_t      pop_item
);

    utf7d_item_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### src/utf7d_back.sv
// Back stage of the UTF-7 decoder: mode state, bit buffer, error hold and
// the output register. Depends on utf7d_pkg.
`default_nettype none

module utf7d_back
    import utf7d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire utf7d_item_t in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_unit,
    output logic [1:0]       out_kind,
    output logic [1:0]       out_err
);

    logic                  in_base64_reg, in_base64_next;
    logic                  no_b64_yet_reg, no_b64_yet_next;
    logic                  emitted_reg, emitted_next;
    logic                  err_hold_reg, err_hold_next;
    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [3:0]            count_reg, count_next;
    logic                  valid_reg, valid_next;
    logic [15:0]           unit_reg, unit_next;
    logic [1:0]            kind_reg, kind_next;
    logic [1:0]            err_reg, err_next;

    logic                  take;
    logic                  res_valid;
    logic                  direct;
    logic                  raise;
    logic [1:0]            raise_code;
    logic [20:0]           acc;
    logic [4:0]            cnt;
    logic [4:0]            rest;
    logic [20:0]           shifted;
    logic [STORE_BITS-1:0] rest_mask;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_kind  = kind_reg;
    assign out_err   = err_reg;

    always_comb
    begin
        take            = in_valid && in_ready;
        in_base64_next  = in_base64_reg;
        no_b64_yet_next = no_b64_yet_reg;
        emitted_next    = emitted_reg;
        err_hold_next   = err_hold_reg;
        store_next      = store_reg;
        count_next      = count_reg;
        res_valid       = 1'b0;
        unit_next       = 16'd0;
        kind_next       = KIND_UNIT;
        err_next        = ERR_NONE;
        direct          = 1'b0;
        raise           = 1'b0;
        raise_code      = ERR_NONE;

        // six more bits appended below the pending ones
        acc       = {store_reg, in_item.b64_val};
        cnt       = {1'b0, count_reg} + 5'd6;
        rest      = cnt - 5'd16;
        shifted   = acc >> rest;
        rest_mask = (STORE_BITS'(1) << rest) - STORE_BITS'(1);

        if (in_item.eos)
        begin
            res_valid = 1'b1;
            kind_next = KIND_END;
            if (!err_hold_reg && in_base64_reg)
            begin
                if (!emitted_reg)
                begin
                    kind_next = KIND_ERR;
                    err_next  = ERR_EMPTY;
                end
                else if (store_reg != '0)
                begin
                    kind_next = KIND_ERR;
                    err_next  = ERR_PAD;
                end
            end
            in_base64_next  = 1'b0;
            no_b64_yet_next = 1'b0;
            emitted_next    = 1'b0;
            err_hold_next   = 1'b0;
            store_next      = '0;
            count_next      = 4'd0;
        end
        else if (!err_hold_reg)
        begin
            if (in_base64_reg)
            begin
                if (in_item.b64_ok)
                begin
                    no_b64_yet_next = 1'b0;
                    if (cnt >= 5'd16)
                    begin
                        unit_next    = shifted[15:0];
                        store_next   = acc[STORE_BITS-1:0] & rest_mask;
                        count_next   = rest[3:0];
                        emitted_next = 1'b1;
                        res_valid    = 1'b1;
                    end
                    else
                    begin
                        store_next = acc[STORE_BITS-1:0];
                        count_next = cnt[3:0];
                    end
                end
                else
                begin
                    in_base64_next = 1'b0;
                    priority if (in_item.is_minus && no_b64_yet_reg)
                    begin
                        // "+-" stands for a literal plus sign
                        store_next = '0;
                        count_next = 4'd0;
                        unit_next  = {8'd0, CHAR_PLUS};
                        res_valid  = 1'b1;
                    end
                    else if (!emitted_reg)
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_EMPTY;
                    end
                    else if (store_reg != '0)
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_PAD;
                    end
                    else
                    begin
                        store_next = '0;
                        count_next = 4'd0;
                        direct     = !in_item.is_minus;
                    end
                end
            end
            else
            begin
                direct = 1'b1;
            end

            if (direct)
            begin
                priority if (in_item.is_plus)
                begin
                    in_base64_next  = 1'b1;
                    no_b64_yet_next = 1'b1;
                    emitted_next    = 1'b0;
                    store_next      = '0;
                    count_next      = 4'd0;
                end
                else if (in_item.high)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_NONASCII;
                end
                else
                begin
                    unit_next = {8'd0, in_item.data_byte};
                    res_valid = 1'b1;
                end
            end

            if (raise)
            begin
                err_hold_next  = 1'b1;
                in_base64_next = 1'b0;
                store_next     = '0;
                count_next     = 4'd0;
                res_valid      = 1'b1;
                unit_next      = 16'd0;
                kind_next      = KIND_ERR;
                err_next       = raise_code;
            end
        end

        if (take)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base64_reg  <= 1'b0;
            no_b64_yet_reg <= 1'b0;
            emitted_reg    <= 1'b0;
            err_hold_reg   <= 1'b0;
            store_reg      <= '0;
            count_reg      <= 4'd0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                in_base64_reg  <= in_base64_next;
                no_b64_yet_reg <= no_b64_yet_next;
                emitted_reg    <= emitted_next;
                err_hold_reg   <= err_hold_next;
                store_reg      <= store_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            unit_reg <= unit_next;
            kind_reg <= kind_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire
